[hw/rtl/plc_pkg.sv]
// shared types and constants for the pgn line classifier
// no dependencies; imported by plc_result_queue, pgn_line_classifier and the testbench
package plc_pkg;

  // request modes
  localparam logic [1:0] MODE_BYTE    = 2'd0;
  localparam logic [1:0] MODE_EOF     = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;

  // line kinds
  localparam logic [2:0] KIND_NONE         = 3'd0;
  localparam logic [2:0] KIND_FIRST_PREFIX = 3'd1;
  localparam logic [2:0] KIND_NEXT_PREFIX  = 3'd2;
  localparam logic [2:0] KIND_FIRST_TAG    = 3'd3;
  localparam logic [2:0] KIND_NEXT_TAG     = 3'd4;
  localparam logic [2:0] KIND_FIRST_MOVES  = 3'd5;
  localparam logic [2:0] KIND_NEXT_MOVES   = 3'd6;
  localparam logic [2:0] KIND_DONE         = 3'd7;

  // character codes
  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;

  // result queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [2:0] kind;
    logic       eoi;
    logic       last;
  } plc_result_t;

  // all results of one request: one or two
  typedef struct packed {
    logic        two;
    plc_result_t first;
    plc_result_t second;
  } plc_entry_t;

  typedef struct packed {
    logic full;
    logic pop;
  } plc_q_status_t;

endpackage

[hw/rtl/pgn_line_classifier.sv]
// pgn_line_classifier: splits chess game text into lines and classifies each line
// depends on plc_pkg and plc_result_queue
//
// usage
//   input channel (in_valid / in_stall, fields mode and ch): one request per cycle
//   unless in_stall; mode 0 carries a text byte, mode 1 marks end of file, mode 2
//   restarts the line machine, mode 3 is ignored
//   output channel (out_valid / out_stall, fields line_kind, end_of_input, last):
//   a line end gives one result; end of file gives a classify result for an
//   unfinished line (last low) and then the done result (last high)
//   path: an accepted request is held in the input register, then processed, and its
//   results are written into the queue, from which the receiver takes them
//   throughput: one request per cycle unless in_stall; each request is handled by the
//   scanner and line machine, the output side moves one result per cycle unless
//   out_stall, so an end of file with an unfinished line gives two output results
//   stalls: the output side buffers result groups in a two-entry queue; when it
//   is full and not draining, the input register holds and in_stall is raised
//   reset: line machine to initial, scanner to leading whitespace, length zero,
//   queue empty
module pgn_line_classifier #(
  parameter int LINE_LIMIT = 2045
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] line_kind,
  output logic       end_of_input,
  output logic       last
);
  import plc_pkg::*;

  localparam int LEN_W = $clog2(LINE_LIMIT + 1);

  // line machine states
  typedef enum logic [2:0] {
    LS_INIT     = 3'd0,
    LS_PREFIX   = 3'd1,
    LS_TAGS     = 3'd2,
    LS_PREMOVES = 3'd3,
    LS_MOVES    = 3'd4,
    LS_SEARCH   = 3'd5
  } line_state_t;

  // scanner phases; tag ok, blank and other hold until the line ends
  typedef enum logic [2:0] {
    PH_LEAD  = 3'd0,
    PH_OPEN  = 3'd1,
    PH_TAG   = 3'd2,
    PH_GAP   = 3'd3,
    PH_VALUE = 3'd4,
    PH_TAGOK = 3'd5,
    PH_BLANK = 3'd6,
    PH_OTHER = 3'd7
  } phase_t;

  typedef struct packed {
    line_state_t st;
    logic [2:0]  kind;
  } line_step_t;

  // one scanner step for one byte; a zero byte drops any phase but tag ok or blank into other
  function automatic phase_t scan_next(phase_t ph, logic [7:0] c);
    logic   ws;
    logic   bad;
    phase_t nx;
    ws  = (c == CH_SPACE) || (c == CH_TAB);
    bad = (c == CH_NUL) || (c == CH_RBRACKET) || (c == CH_QUOTE);
    nx  = ph;
    unique case (ph)
      PH_LEAD: begin
        if (!ws) begin
          if ((c == CH_LF) || (c == CH_CR)) nx = PH_BLANK;
          else if (c == CH_LBRACKET)       nx = PH_OPEN;
          else                             nx = PH_OTHER;
        end
      end
      PH_OPEN: begin
        if (!ws) nx = bad ? PH_OTHER : PH_TAG;
      end
      PH_TAG: begin
        if (ws)       nx = PH_GAP;
        else if (bad) nx = PH_OTHER;
      end
      PH_GAP: begin
        if (!ws) nx = (c == CH_QUOTE) ? PH_VALUE : PH_OTHER;
      end
      PH_VALUE: begin
        if (c == CH_QUOTE)    nx = PH_TAGOK;
        else if (c == CH_NUL) nx = PH_OTHER;
      end
      default: nx = ph;
    endcase
    return nx;
  endfunction

  // line machine step taken when a line finishes
  function automatic line_step_t line_finish(line_state_t ls, phase_t ph);
    logic       tag;
    logic       blank;
    line_step_t r;
    tag    = (ph == PH_TAGOK);
    blank  = (ph == PH_BLANK);
    r.st   = ls;
    r.kind = KIND_NONE;
    unique case (ls)
      LS_INIT, LS_SEARCH: begin
        if (tag) begin
          r.st = LS_TAGS; r.kind = KIND_FIRST_TAG;
        end else if (!blank) begin
          r.st = LS_PREFIX; r.kind = KIND_FIRST_PREFIX;
        end
      end
      LS_PREFIX: begin
        if (tag) begin
          r.st = LS_TAGS; r.kind = KIND_FIRST_TAG;
        end else begin
          r.kind = KIND_NEXT_PREFIX;
        end
      end
      LS_TAGS: begin
        if (tag) begin
          r.kind = KIND_NEXT_TAG;
        end else if (blank) begin
          r.st = LS_PREMOVES;
        end else begin
          r.st = LS_MOVES; r.kind = KIND_FIRST_MOVES;
        end
      end
      LS_PREMOVES: begin
        if (!blank) begin
          r.st = LS_MOVES; r.kind = KIND_FIRST_MOVES;
        end
      end
      LS_MOVES: begin
        if (blank) begin
          r.st = LS_SEARCH; r.kind = KIND_DONE;
        end else begin
          r.kind = KIND_NEXT_MOVES;
        end
      end
      default: r.st = LS_INIT;
    endcase
    return r;
  endfunction

  // input register
  logic        s1_valid;
  logic [1:0]  s1_mode;
  logic [7:0]  s1_ch;

  // block state
  line_state_t line_state;
  line_state_t line_state_next;
  phase_t      scan_phase;
  phase_t      scan_phase_next;
  logic [LEN_W-1:0] line_length;
  logic [LEN_W-1:0] line_length_next;

  // processing
  phase_t           ph_scan;
  logic [LEN_W-1:0] len_inc;
  logic             byte_ends;
  line_step_t       fin_byte;
  line_step_t       fin_eof;
  line_state_t      eof_state;
  logic [2:0]       done_kind;
  logic             push_ok;
  logic             push;
  plc_entry_t       entry;
  plc_q_status_t    q_status;

  // the queue can take a group when not full or when its head leaves this cycle
  assign push_ok  = !q_status.full || q_status.pop;
  assign in_stall = s1_valid && !push_ok;

  assign ph_scan   = scan_next(scan_phase, s1_ch);
  assign len_inc   = line_length + LEN_W'(1);
  // length never passes the limit, so the increment cannot wrap
  assign byte_ends = (s1_ch == CH_LF) || (len_inc >= LEN_W'(LINE_LIMIT));
  assign fin_byte  = line_finish(line_state, ph_scan);
  assign fin_eof   = line_finish(line_state, scan_phase);
  assign eof_state = (line_length != '0) ? fin_eof.st : line_state;
  assign done_kind = (eof_state == LS_MOVES) ? KIND_DONE : KIND_NONE;

  always_comb begin
    line_state_next  = line_state;
    scan_phase_next  = scan_phase;
    line_length_next = line_length;
    push             = 1'b0;
    entry            = '0;
    if (s1_valid && push_ok) begin
      unique case (s1_mode)
        MODE_BYTE: begin
          if (byte_ends) begin
            line_state_next  = fin_byte.st;
            scan_phase_next  = PH_LEAD;
            line_length_next = '0;
            push             = 1'b1;
            entry.first      = '{kind: fin_byte.kind, eoi: 1'b0, last: 1'b1};
          end else begin
            scan_phase_next  = ph_scan;
            line_length_next = len_inc;
          end
        end
        MODE_EOF: begin
          push = 1'b1;
          if (line_length != '0) begin
            // classify the unfinished line, then report done
            line_state_next  = fin_eof.st;
            scan_phase_next  = PH_LEAD;
            line_length_next = '0;
            entry.two        = 1'b1;
            entry.first      = '{kind: fin_eof.kind, eoi: 1'b0, last: 1'b0};
            entry.second     = '{kind: done_kind, eoi: 1'b1, last: 1'b1};
          end else begin
            entry.first      = '{kind: done_kind, eoi: 1'b1, last: 1'b1};
          end
        end
        MODE_RESTART: begin
          line_state_next  = LS_INIT;
          scan_phase_next  = PH_LEAD;
          line_length_next = '0;
        end
        default: begin
          // unused mode, no effect
          line_state_next = line_state;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      line_state  <= LS_INIT;
      scan_phase  <= PH_LEAD;
      line_length <= '0;
    end else begin
      line_state  <= line_state_next;
      scan_phase  <= scan_phase_next;
      line_length <= line_length_next;
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
    end
    if (in_valid && !in_stall) begin
      s1_mode <= mode;
      s1_ch   <= ch;
    end
  end

  // result groups wait here until the receiver takes them
  plc_result_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_entry   (entry),
    .status       (q_status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .line_kind    (line_kind),
    .end_of_input (end_of_input),
    .last         (last)
  );

endmodule

[hw/rtl/plc_result_queue.sv]
// small queue of per-request result groups, unpacked one result per cycle unless out_stall
// depends on plc_pkg
module plc_result_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  plc_pkg::plc_entry_t   push_entry,
  output plc_pkg::plc_q_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [2:0]            line_kind,
  output logic                  end_of_input,
  output logic                  last
);
  import plc_pkg::*;

  plc_entry_t          entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   head;
  logic [QPTR_W-1:0]   tail;
  logic [QCNT_W-1:0]   count;
  logic                sel;
  plc_entry_t          head_entry;
  plc_result_t         cur;
  logic                take;
  logic                pop;

  assign head_entry = entries[head];
  assign cur        = sel ? head_entry.second : head_entry.first;
  assign out_valid  = (count != '0);
  assign take       = out_valid && !out_stall;
  // entry leaves once its final result is taken
  assign pop        = take && (sel || !head_entry.two);

  assign line_kind    = cur.kind;
  assign end_of_input = cur.eoi;
  assign last         = cur.last;

  assign status.full = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.pop  = pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      sel   <= 1'b0;
    end else begin
      if (push) begin
        entries[tail] <= push_entry;
        tail <= (tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + QPTR_W'(1);
      end
      if (pop) begin
        head <= (head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
      if (take) begin
        sel <= !pop;
      end
    end
  end

endmodule

[dv/pgn_line_classifier_tb.sv]
// self-checking testbench for pgn_line_classifier: drives text bytes, end of file,
// restart and unused requests, predicts every line kind and checks each result
// depends on plc_pkg and the pgn_line_classifier rtl
`timescale 1ns / 100ps

module pgn_line_classifier_tb;
  import plc_pkg::*;

  localparam int LINE_LIMIT  = 2045;
  localparam int RANDOM_REQS = 1400;     // random requests that the block acts on
  localparam int CYCLE_LIMIT = 400000;   // far above the slowest correct run
  localparam int IDLE_PCT    = 24;
  localparam int REPORT_CAP  = 40;

  // the fourth mode is not defined, the block must ignore it
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  // line machine of the predictor
  typedef enum logic [2:0] {
    LM_INIT, LM_PREFIX, LM_TAGS, LM_PREMOVES, LM_MOVES, LM_SEARCH
  } line_machine_e;

  // tag scanner phases of the predictor
  typedef enum logic [2:0] {
    SC_LEAD, SC_OPEN, SC_TAG, SC_GAP, SC_VALUE, SC_TAGOK, SC_BLANK, SC_OTHER
  } scan_phase_e;

  // shapes of generated text lines
  typedef enum logic [1:0] {
    LINE_TAG, LINE_BLANK, LINE_MOVES, LINE_NOISE
  } line_form_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] mode = MODE_BYTE;
  logic [7:0] ch = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] line_kind;
  logic       end_of_input;
  logic       last;

  // predictor state
  line_machine_e lm_state;
  scan_phase_e   scan_ph;
  logic [11:0]   line_len;

  plc_result_t expected_q[$];
  logic [7:0]  line_buf[$];

  int  mismatch_count = 0;
  int  requests_sent = 0;
  int  cycle_count = 0;
  bit  idle_en = 1'b1;

  pgn_line_classifier #(
    .LINE_LIMIT(LINE_LIMIT)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .ch          (ch),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .line_kind   (line_kind),
    .end_of_input(end_of_input),
    .last        (last)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver back-pressure, switched off during the quiet stretch
  always @(negedge clk) begin
    out_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  // bytes that spoil a tag name
  function automatic bit spoils_tag(logic [7:0] c);
    return c == CH_NUL || c == CH_RBRACKET || c == CH_QUOTE;
  endfunction

  function automatic void clear_predictor();
    lm_state = LM_INIT;
    scan_ph  = SC_LEAD;
    line_len = '0;
  endfunction

  // one step of the tag / blank scanner; a zero byte freezes it as "other" unless in tag ok or blank
  function automatic void scan_char(logic [7:0] c);
    case (scan_ph)
      SC_LEAD: begin
        if (!is_space(c)) begin
          if (c == CH_LF || c == CH_CR) scan_ph = SC_BLANK;
          else if (c == CH_LBRACKET) scan_ph = SC_OPEN;
          else scan_ph = SC_OTHER;
        end
      end
      SC_OPEN: begin
        if (!is_space(c)) scan_ph = spoils_tag(c) ? SC_OTHER : SC_TAG;
      end
      SC_TAG: begin
        if (is_space(c)) scan_ph = SC_GAP;
        else if (spoils_tag(c)) scan_ph = SC_OTHER;
      end
      SC_GAP: begin
        if (!is_space(c)) scan_ph = (c == CH_QUOTE) ? SC_VALUE : SC_OTHER;
      end
      SC_VALUE: begin
        if (c == CH_QUOTE) scan_ph = SC_TAGOK;
        else if (c == CH_NUL) scan_ph = SC_OTHER;
      end
      default: ;
    endcase
  endfunction

  // close the current line: advance the line machine and give its kind
  function automatic logic [2:0] close_line();
    bit         tag_ok;
    bit         blank;
    logic [2:0] kind;
    tag_ok = (scan_ph == SC_TAGOK);
    blank  = (scan_ph == SC_BLANK);
    kind   = KIND_NONE;
    case (lm_state)
      LM_INIT, LM_SEARCH: begin
        if (tag_ok) begin
          lm_state = LM_TAGS;
          kind = KIND_FIRST_TAG;
        end else if (!blank) begin
          lm_state = LM_PREFIX;
          kind = KIND_FIRST_PREFIX;
        end
      end
      LM_PREFIX: begin
        if (tag_ok) begin
          lm_state = LM_TAGS;
          kind = KIND_FIRST_TAG;
        end else begin
          kind = KIND_NEXT_PREFIX;
        end
      end
      LM_TAGS: begin
        if (tag_ok) begin
          kind = KIND_NEXT_TAG;
        end else if (blank) begin
          lm_state = LM_PREMOVES;
        end else begin
          lm_state = LM_MOVES;
          kind = KIND_FIRST_MOVES;
        end
      end
      LM_PREMOVES: begin
        if (!blank) begin
          lm_state = LM_MOVES;
          kind = KIND_FIRST_MOVES;
        end
      end
      LM_MOVES: begin
        if (blank) begin
          lm_state = LM_SEARCH;
          kind = KIND_DONE;
        end else begin
          kind = KIND_NEXT_MOVES;
        end
      end
      default: lm_state = LM_INIT;
    endcase
    scan_ph  = SC_LEAD;
    line_len = '0;
    return kind;
  endfunction

  function automatic void push_expected(logic [2:0] kind, logic eoi, logic fin);
    plc_result_t r;
    r.kind = kind;
    r.eoi  = eoi;
    r.last = fin;
    expected_q = {expected_q, r};
  endfunction

  // expected results of one accepted request
  function automatic void predict_request(logic [1:0] m, logic [7:0] c);
    case (m)
      MODE_BYTE: begin
        scan_char(c);
        line_len = line_len + 12'd1;
        if (c == CH_LF || line_len >= LINE_LIMIT) push_expected(close_line(), 1'b0, 1'b1);
      end
      MODE_EOF: begin
        // an unfinished line is classified before the done report
        if (line_len != 0) push_expected(close_line(), 1'b0, 1'b0);
        push_expected((lm_state == LM_MOVES) ? KIND_DONE : KIND_NONE, 1'b1, 1'b1);
      end
      MODE_RESTART: clear_predictor();
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_CAP) $display("%0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin : check_results
    plc_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result arrived with none outstanding");
      end else begin
        want = expected_q.pop_front();
        if (line_kind !== want.kind)
          report_mismatch($sformatf("line_kind %0d, wanted %0d", line_kind, want.kind));
        if (end_of_input !== want.eoi)
          report_mismatch($sformatf("end_of_input %0b, wanted %0b", end_of_input, want.eoi));
        if (last !== want.last)
          report_mismatch($sformatf("last %0b, wanted %0b", last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request driving
  // ---------------------------------------------------------------------------

  // one request: random idle cycles first, then hold until accepted
  task automatic send_item(logic [1:0] m, logic [7:0] c);
    @(negedge clk);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    ch       <= c;
    do @(posedge clk); while (in_stall);
    predict_request(m, c);
    if (m != MODE_UNUSED) requests_sent++;
  endtask

  task automatic send_text(string s);
    foreach (s[i]) send_item(MODE_BYTE, s[i]);
  endtask

  // sender holds off until every outstanding result has been taken
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] any_space();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  function automatic logic [7:0] printable();
    return 8'($urandom_range(32, 126));
  endfunction

  // build one line of the given shape in line_buf, sometimes damaged, then send it
  task automatic send_line(line_form_e form);
    line_buf.delete();
    case (form)
      LINE_TAG: begin
        if ($urandom_range(3) == 0) line_buf = {line_buf, any_space()};
        line_buf = {line_buf, CH_LBRACKET};
        if ($urandom_range(5) == 0) line_buf = {line_buf, any_space()};
        repeat ($urandom_range(1, 5)) line_buf = {line_buf, 8'($urandom_range(65, 122))};
        repeat ($urandom_range(1, 2)) line_buf = {line_buf, any_space()};
        line_buf = {line_buf, CH_QUOTE};
        repeat ($urandom_range(0, 6)) line_buf = {line_buf, printable()};
        line_buf = {line_buf, CH_QUOTE};
        line_buf = {line_buf, CH_RBRACKET};
        // truncated or corrupted tag lines now and then
        case ($urandom_range(9))
          0: repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
          1: line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
          2: line_buf.insert($urandom_range(line_buf.size() - 1), CH_NUL);
          default: ;
        endcase
      end
      LINE_BLANK: begin
        repeat ($urandom_range(0, 2)) line_buf = {line_buf, any_space()};
      end
      LINE_MOVES: begin
        repeat ($urandom_range(1, 12)) line_buf = {line_buf, printable()};
      end
      default: begin
        repeat ($urandom_range(1, 8)) line_buf = {line_buf, 8'($urandom_range(255))};
      end
    endcase
    if ($urandom_range(3) == 0) line_buf = {line_buf, CH_CR};
    line_buf = {line_buf, CH_LF};
    foreach (line_buf[i]) send_item(MODE_BYTE, line_buf[i]);
  endtask

  // mostly the intended shape, occasionally any shape
  function automatic line_form_e mostly(line_form_e form);
    return ($urandom_range(9) == 0) ? line_form_e'($urandom_range(3)) : form;
  endfunction

  // a game: tag section, separator, move text, closing blank line
  task automatic send_game();
    repeat ($urandom_range(1, 5)) send_line(mostly(LINE_TAG));
    if ($urandom_range(9) != 0) send_line(mostly(LINE_BLANK));
    repeat ($urandom_range(1, 4)) send_line(mostly(LINE_MOVES));
    if ($urandom_range(4) != 0) send_line(mostly(LINE_BLANK));
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_reset();
    clear_predictor();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  endtask

  // tag, blank separator with carriage return, moves, end of file twice,
  // then the blank line that closes the game
  task automatic test_game_flow();
    send_text("[a \"\"]\n");
    send_item(MODE_BYTE, CH_CR);
    send_item(MODE_BYTE, CH_LF);
    send_text("1\n");
    send_item(MODE_EOF, 8'h00);
    send_item(MODE_EOF, 8'hFF);
    send_text("\n");
    wait_drained();
  endtask

  // zero byte and top byte in one line, unused mode, restart mid line,
  // a whitespace-only line cut short by end of file
  task automatic test_special_requests();
    send_item(MODE_BYTE, CH_NUL);
    send_item(MODE_BYTE, 8'hFF);
    send_item(MODE_BYTE, CH_LF);
    send_item(MODE_UNUSED, 8'hFF);
    send_item(MODE_BYTE, "x");
    send_item(MODE_RESTART, 8'hAA);
    send_item(MODE_BYTE, CH_TAB);
    send_item(MODE_EOF, 8'h55);
    wait_drained();
  endtask

  // lines that reach the length limit
  task automatic test_line_limit();
    // text with no newline closes at the limit, the newline after it is a line of its own
    repeat (LINE_LIMIT) send_item(MODE_BYTE, printable());
    send_item(MODE_BYTE, CH_LF);
    // newline landing exactly on the limit closes the line once
    repeat (LINE_LIMIT - 1) send_item(MODE_BYTE, any_space());
    send_item(MODE_BYTE, CH_LF);
    // whitespace only up to the limit is neither blank nor a tag
    repeat (LINE_LIMIT) send_item(MODE_BYTE, any_space());
    send_item(MODE_EOF, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_traffic();
    requests_sent = 0;
    while (requests_sent < RANDOM_REQS) begin
      // quiet stretch with no idling on either side
      idle_en = !(requests_sent >= 500 && requests_sent < 800);
      case ($urandom_range(19))
        0: send_item(MODE_EOF, 8'($urandom_range(255)));
        1: send_item(MODE_RESTART, 8'($urandom_range(255)));
        2: send_item(MODE_UNUSED, 8'($urandom_range(255)));
        3: begin
          // unfinished line, then end of file or restart
          repeat ($urandom_range(1, 6)) send_item(MODE_BYTE, 8'($urandom_range(255)));
          send_item($urandom_range(1) ? MODE_EOF : MODE_RESTART, 8'($urandom_range(255)));
        end
        4: send_line(line_form_e'($urandom_range(3)));
        5: wait_drained();
        default: send_game();
      endcase
    end
    idle_en = 1'b1;
  endtask

  initial begin
    test_reset();
    test_game_flow();
    test_special_requests();
    test_line_limit();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

[files.f]
hw/rtl/plc_pkg.sv
hw/rtl/plc_result_queue.sv
hw/rtl/pgn_line_classifier.sv
dv/pgn_line_classifier_tb.sv
